### hdl/scaled_glyph_column_renderer_top_defines.svh
// Assertion macros used by the checker of the glyph renderer.
`ifndef SCALED_GLYPH_COLUMN_RENDERER_TOP_DEFINES_SVH
`define SCALED_GLYPH_COLUMN_RENDERER_TOP_DEFINES_SVH

// The antecedent implies the consequent in the same cycle.
`define SGCR_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("glyph renderer check failed");

// The antecedent implies the consequent in the following cycle.
`define SGCR_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("glyph renderer check failed");

`endif

### hdl/sgcr_pkg.sv
// Package of the glyph renderer: font ROM, glyph lookup, stretching and job type.
package sgcr_pkg;

	localparam int GLYPH_WIDTH = 5;
	localparam int GLYPH_ROWS = 7;
	localparam int MAX_SCALE = 3;
	localparam int GLYPH_COUNT = 39;
	localparam int QUEUE_DEPTH = 2;
	localparam int IDX_W = $clog2(GLYPH_COUNT);
	localparam int COL_W = $clog2(GLYPH_WIDTH);
	localparam int STRETCH_W = 8 * MAX_SCALE;

	localparam logic [IDX_W-1:0] IDX_SPACE = IDX_W'(0);
	localparam logic [IDX_W-1:0] IDX_DIGIT0 = IDX_W'(1);
	localparam logic [IDX_W-1:0] IDX_DEGREE = IDX_W'(11);
	localparam logic [IDX_W-1:0] IDX_MINUS = IDX_W'(12);
	localparam logic [IDX_W-1:0] IDX_LETTER_A = IDX_W'(13);

	localparam logic [7:0] CODE_SPACE = 8'h20;
	localparam logic [7:0] CODE_MINUS = 8'h2D;
	localparam logic [7:0] CODE_DIGIT0 = 8'h30;
	localparam logic [7:0] CODE_DIGIT9 = 8'h39;
	localparam logic [7:0] CODE_LETTER_A = 8'h41;
	localparam logic [7:0] CODE_LETTER_Z = 8'h5A;
	localparam logic [7:0] CODE_DEGREE = 8'd248;

	// Each entry holds the five columns, column zero in the lowest seven bits.
	localparam logic [GLYPH_WIDTH*GLYPH_ROWS-1:0] GLYPH_ROM [GLYPH_COUNT] = '{
		{7'h00, 7'h00, 7'h00, 7'h00, 7'h00},
		{7'h3E, 7'h45, 7'h49, 7'h51, 7'h3E},
		{7'h00, 7'h40, 7'h7F, 7'h42, 7'h00},
		{7'h46, 7'h49, 7'h49, 7'h51, 7'h62},
		{7'h36, 7'h49, 7'h49, 7'h41, 7'h22},
		{7'h10, 7'h7F, 7'h12, 7'h14, 7'h18},
		{7'h31, 7'h49, 7'h49, 7'h49, 7'h2F},
		{7'h30, 7'h49, 7'h49, 7'h4A, 7'h3C},
		{7'h03, 7'h05, 7'h09, 7'h71, 7'h01},
		{7'h36, 7'h49, 7'h49, 7'h49, 7'h36},
		{7'h1E, 7'h29, 7'h49, 7'h49, 7'h06},
		{7'h00, 7'h06, 7'h09, 7'h09, 7'h06},
		{7'h08, 7'h08, 7'h08, 7'h08, 7'h08},
		{7'h7E, 7'h11, 7'h11, 7'h11, 7'h7E},
		{7'h36, 7'h49, 7'h49, 7'h49, 7'h7F},
		{7'h22, 7'h41, 7'h41, 7'h41, 7'h3E},
		{7'h3E, 7'h41, 7'h41, 7'h41, 7'h7F},
		{7'h41, 7'h49, 7'h49, 7'h49, 7'h7F},
		{7'h01, 7'h09, 7'h09, 7'h09, 7'h7F},
		{7'h7A, 7'h49, 7'h49, 7'h41, 7'h3E},
		{7'h7F, 7'h08, 7'h08, 7'h08, 7'h7F},
		{7'h00, 7'h41, 7'h7F, 7'h41, 7'h00},
		{7'h3F, 7'h40, 7'h40, 7'h40, 7'h30},
		{7'h41, 7'h22, 7'h14, 7'h08, 7'h7F},
		{7'h40, 7'h40, 7'h40, 7'h40, 7'h7F},
		{7'h7F, 7'h02, 7'h04, 7'h02, 7'h7F},
		{7'h7F, 7'h10, 7'h08, 7'h04, 7'h7F},
		{7'h3E, 7'h41, 7'h41, 7'h41, 7'h3E},
		{7'h06, 7'h09, 7'h09, 7'h09, 7'h7F},
		{7'h5E, 7'h21, 7'h51, 7'h41, 7'h3E},
		{7'h46, 7'h29, 7'h19, 7'h09, 7'h7F},
		{7'h31, 7'h49, 7'h49, 7'h49, 7'h46},
		{7'h01, 7'h01, 7'h7F, 7'h01, 7'h01},
		{7'h3F, 7'h40, 7'h40, 7'h40, 7'h3F},
		{7'h1F, 7'h20, 7'h40, 7'h20, 7'h1F},
		{7'h3F, 7'h40, 7'h38, 7'h40, 7'h3F},
		{7'h63, 7'h14, 7'h08, 7'h14, 7'h63},
		{7'h03, 7'h04, 7'h78, 7'h04, 7'h03},
		{7'h41, 7'h61, 7'h51, 7'h49, 7'h47}
	};

	typedef struct packed {
		logic [IDX_W-1:0] idx;
		logic [1:0] scale;
		logic [2:0] top_page;
		logic [6:0] left_col;
	} glyph_job_t;

	typedef struct packed {
		logic hit;
		logic [IDX_W-1:0] idx;
	} glyph_lookup_t;

	typedef enum logic {
		BK_IDLE,
		BK_RUN
	} back_state_t;

	function automatic glyph_lookup_t glyph_lookup(input logic [7:0] code);
		glyph_lookup_t r;
		r.hit = 1'b1;
		r.idx = IDX_SPACE;
		if (code >= CODE_DIGIT0 && code <= CODE_DIGIT9) begin
			r.idx = IDX_W'(code - CODE_DIGIT0) + IDX_DIGIT0;
		end else if (code >= CODE_LETTER_A && code <= CODE_LETTER_Z) begin
			r.idx = IDX_W'(code - CODE_LETTER_A) + IDX_LETTER_A;
		end else if (code == CODE_DEGREE) begin
			r.idx = IDX_DEGREE;
		end else if (code == CODE_MINUS) begin
			r.idx = IDX_MINUS;
		end else if (code != CODE_SPACE) begin
			r.hit = 1'b0;
		end
		return r;
	endfunction

	// Repeats every pixel of a column scale times downward.
	function automatic logic [STRETCH_W-1:0] stretch_column(input logic [GLYPH_ROWS-1:0] bits,
			input logic [1:0] scale);
		logic [STRETCH_W-1:0] r;
		r = '0;
		for (int row = 0; row < STRETCH_W; row++) begin
			case (scale)
				2'd1: r[row] = (row < GLYPH_ROWS) ? bits[row % GLYPH_ROWS] : 1'b0;
				2'd2: r[row] = (row < 2 * GLYPH_ROWS) ? bits[(row / 2) % GLYPH_ROWS] : 1'b0;
				2'd3: r[row] = (row < 3 * GLYPH_ROWS) ? bits[(row / 3) % GLYPH_ROWS] : 1'b0;
				default: r[row] = 1'b0;
			endcase
		end
		return r;
	endfunction

endpackage

### hdl/scaled_glyph_column_renderer_top.sv
// Top level of the scaled glyph column renderer.
//
// Channel  Dir  Payload (lowest bit first)                          Marker
// s_axis   in   char_code[7:0] scale[9:8] top_page[12:10]           -
//               left_col[19:13]
// m_axis   out  page[3:0] column[11:4] pixels[19:12]                tlast = last
//
// A character at scale s gives 5*s*s writes (45 at scale three), one a cycle unless stalled.
// A job is taken from the queue in the idle state; its first write is issued in the run state.
// Unsupported codes and scale zero are dropped in the front end.
// The reset is asynchronous and needs no clearing pass; the font lives in constant logic.
// Input transfers stall only when the job queue is full; output stalls hold the write register.
module scaled_glyph_column_renderer_top import sgcr_pkg::*; #(
	parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // char_code, scale, top_page, left_col
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // page, column, pixels
	output logic        m_axis_tlast
);

	logic push;
	logic pop;
	logic queue_full;
	logic queue_empty;
	glyph_job_t push_job;
	glyph_job_t head_job;

	sgcr_front u_front (
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.queue_full    (queue_full),
		.push          (push),
		.push_job      (push_job)
	);

	sgcr_queue #(
		.DEPTH (QUEUE_DEPTH_P)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head_job (head_job),
		.full     (queue_full),
		.empty    (queue_empty)
	);

	sgcr_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.queue_empty   (queue_empty),
		.head_job      (head_job),
		.pop           (pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

### hdl/sgcr_front.sv
// Front end: takes characters, looks up the glyph and queues a render job.
module sgcr_front import sgcr_pkg::*; (
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	input  logic [23:0]      s_axis_tdata,
	input  logic             queue_full,
	output logic             push,
	output glyph_job_t       push_job
);

	glyph_lookup_t lookup;
	logic [1:0] scale_sat;

	// A transfer is taken only while the queue has room.
	assign s_axis_tready = !queue_full;

	always_comb begin
		lookup = glyph_lookup(s_axis_tdata[7:0]);
		scale_sat = (s_axis_tdata[9:8] > 2'(MAX_SCALE)) ? 2'(MAX_SCALE) : s_axis_tdata[9:8];
		push_job.idx = lookup.idx;
		push_job.scale = scale_sat;
		push_job.top_page = s_axis_tdata[12:10];
		push_job.left_col = s_axis_tdata[19:13];
		push = s_axis_tvalid && s_axis_tready && lookup.hit && (scale_sat != 2'd0);
	end

endmodule

### hdl/sgcr_queue.sv
// Small job queue between the front end and the write sequencer.
module sgcr_queue import sgcr_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  glyph_job_t push_job,
	input  logic       pop,
	output glyph_job_t head_job,
	output logic       full,
	output logic       empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	glyph_job_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign head_job = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

endmodule

### hdl/sgcr_back.sv
// Back end: steps through columns, copies and pages and issues the display writes.
module sgcr_back import sgcr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        queue_empty,
	input  glyph_job_t  head_job,
	output logic        pop,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,
	output logic        m_axis_tlast
);

	back_state_t state_q, state_d;
	glyph_job_t job_q;
	logic [COL_W-1:0] c_q;
	logic [1:0] x_q;
	logic [1:0] p_q;
	logic [7:0] col_q;

	logic m_valid_q;
	logic [3:0] page_q;
	logic [7:0] column_q;
	logic [7:0] pixels_q;
	logic last_q;

	logic emit;
	logic advance;
	logic scale_end_x;
	logic scale_end_p;
	logic is_last;
	logic [GLYPH_ROWS-1:0] col_bits;
	logic [STRETCH_W-1:0] stretched;
	logic [7:0] page_byte;

	assign advance = !m_valid_q || m_axis_tready;
	assign scale_end_x = (x_q == job_q.scale - 2'd1);
	assign scale_end_p = (p_q == job_q.scale - 2'd1);
	assign is_last = (c_q == COL_W'(GLYPH_WIDTH - 1)) && scale_end_x && scale_end_p;

	always_comb begin
		col_bits = GLYPH_ROM[job_q.idx][c_q * GLYPH_ROWS +: GLYPH_ROWS];
		stretched = stretch_column(col_bits, job_q.scale);
		page_byte = stretched[p_q * 8 +: 8];
	end

	always_comb begin
		state_d = state_q;
		pop = 1'b0;
		emit = 1'b0;
		case (state_q)
			BK_IDLE: begin
				if (!queue_empty) begin
					pop = 1'b1;
					state_d = BK_RUN;
				end
			end
			BK_RUN: begin
				if (advance) begin
					emit = 1'b1;
					if (is_last) begin
						state_d = BK_IDLE;
					end
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			m_valid_q <= 1'b0;
			c_q <= '0;
			x_q <= '0;
			p_q <= '0;
		end else begin
			state_q <= state_d;
			if (emit) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			if (pop) begin
				c_q <= '0;
				x_q <= '0;
				p_q <= '0;
			end else if (emit) begin
				if (scale_end_p) begin
					p_q <= '0;
					if (scale_end_x) begin
						x_q <= '0;
						c_q <= c_q + 1'b1;
					end else begin
						x_q <= x_q + 1'b1;
					end
				end else begin
					p_q <= p_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= head_job;
			col_q <= {1'b0, head_job.left_col};
		end else if (emit && scale_end_p) begin
			col_q <= col_q + 8'd1;
		end
		if (emit) begin
			page_q <= {1'b0, job_q.top_page} + {2'b00, p_q};
			column_q <= col_q;
			pixels_q <= page_byte;
			last_q <= is_last;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata = {4'h0, pixels_q, column_q, page_q};
	assign m_axis_tlast = last_q;

endmodule

### hdl/sgcr_checker.sv
// Port checker of the glyph renderer and its binding to the top level.
`include "scaled_glyph_column_renderer_top_defines.svh"

module sgcr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [23:0] s_axis_tdata,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [23:0] m_axis_tdata,
	input logic        m_axis_tlast
);

	// A stalled write stays offered and unchanged.
	`SGCR_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
	`SGCR_ASSERT_NEXT(a_out_stable, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata) && $stable(m_axis_tlast))
	// Pages stay on the stretched glyph and the padding bits are zero.
	`SGCR_ASSERT_NOW(a_page_range, m_axis_tvalid, m_axis_tdata[3:0] <= 4'd9 && m_axis_tdata[23:20] == 4'h0)
	// Within one character the writes follow each other without a gap.
	`SGCR_ASSERT_NEXT(a_no_gap, m_axis_tvalid && m_axis_tready && !m_axis_tlast, m_axis_tvalid)

endmodule

bind scaled_glyph_column_renderer_top sgcr_checker u_sgcr_checker (.*);
